/* sv/bdlp_pkg.sv */
// bdlp_pkg: shared widths, register indexes and types for the button debounce block
// no dependencies; imported by all bdlp modules and the top level
package bdlp_pkg;

    // tick counter width, both counters saturate at its all-ones value
    localparam int COUNT_WIDTH = 16;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    // configuration port
    localparam int CFG_DATA_W = 16;
    localparam int REG_IDX_W  = 2;
    localparam logic [REG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FILTER_TICKS     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_INIT_PREV_LEVEL  = 2'd2;

    // reset values of the registers
    localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RST = 16'd1000;
    localparam logic [CFG_DATA_W-1:0] FILTER_RST     = 16'd20;

    // width for comparing a counter with a threshold register
    localparam int CMP_W = (COUNT_WIDTH > CFG_DATA_W) ? COUNT_WIDTH : CFG_DATA_W;

    // status flags, bit 0 is was_pressed
    typedef struct packed {
        logic was_long;
        logic pressed_long;
        logic was_short;
        logic pressed_short;
        logic was_released;
        logic was_pressed;
    } t_flags;

    // sticky flag clear requests of one tick
    typedef struct packed {
        logic was_pressed;
        logic was_released;
        logic was_short;
        logic was_long;
    } t_clears;

    // control from the top level to the press tracker
    typedef struct packed {
        logic    step;
        t_clears clr;
        logic    load_prev;
        logic    prev_val;
    } t_press_ctl;

    // one result item
    typedef struct packed {
        logic   pressed;
        t_flags flags;
    } t_result;

endpackage

/* sv/bdlp_in_if.sv */
// bdlp_in_if: tick channel into the button debounce block
// valid / ready handshake with the raw level and the sticky clear requests
interface bdlp_in_if;
    logic valid;
    logic ready;
    logic raw_pressed;
    logic clear_was_pressed;
    logic clear_was_released;
    logic clear_was_short;
    logic clear_was_long;

    modport source (
        output valid, raw_pressed, clear_was_pressed, clear_was_released,
               clear_was_short, clear_was_long,
        input  ready
    );
    modport sink (
        input  valid, raw_pressed, clear_was_pressed, clear_was_released,
               clear_was_short, clear_was_long,
        output ready
    );
endinterface

/* sv/bdlp_out_if.sv */
// bdlp_out_if: result channel out of the button debounce block
// valid / ready handshake with the filtered level and the status flags
interface bdlp_out_if;
    logic valid;
    logic ready;
    logic pressed;
    logic was_pressed;
    logic was_released;
    logic pressed_short;
    logic was_pressed_short;
    logic pressed_long;
    logic was_pressed_long;

    modport source (
        output valid, pressed, was_pressed, was_released, pressed_short,
               was_pressed_short, pressed_long, was_pressed_long,
        input  ready
    );
    modport sink (
        input  valid, pressed, was_pressed, was_released, pressed_short,
               was_pressed_short, pressed_long, was_pressed_long,
        output ready
    );
endinterface

/* sv/bdlp_filter.sv */
// bdlp_filter: glitch filter on the raw button level
// depends on bdlp_pkg; the filtered level flips after filter_ticks differing ticks
module bdlp_filter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  logic                             i_raw,
    input  logic [bdlp_pkg::CFG_DATA_W-1:0]  i_filter_ticks,
    output logic                             o_level_next
);
    import bdlp_pkg::*;

    logic                   r_level;
    logic [COUNT_WIDTH-1:0] r_count;
    logic                   n_level;
    logic [COUNT_WIDTH-1:0] n_count;
    logic [COUNT_WIDTH-1:0] count_inc;

    // saturating count of differing ticks, flip once the threshold is met
    always_comb begin
        count_inc = (r_count == CNT_MAX) ? r_count : r_count + 1'b1;
        n_level   = r_level;
        n_count   = '0;
        if (i_raw != r_level) begin
            if (CMP_W'(count_inc) >= CMP_W'(i_filter_ticks)) begin
                n_level = i_raw;
            end else begin
                n_count = count_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= 1'b0;
            r_count <= '0;
        end else if (i_step) begin
            r_level <= n_level;
            r_count <= n_count;
        end
    end

    assign o_level_next = n_level;

endmodule

/* sv/bdlp_press.sv */
// bdlp_press: press timer, short / long classification and sticky flags
// depends on bdlp_pkg; takes the filtered level of the current tick from bdlp_filter
module bdlp_press (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bdlp_pkg::t_press_ctl             i_ctl,
    input  logic                             i_level,
    input  logic [bdlp_pkg::CFG_DATA_W-1:0]  i_long_ticks,
    output bdlp_pkg::t_flags                 o_flags_next
);
    import bdlp_pkg::*;

    logic                   r_prev;
    logic [COUNT_WIDTH-1:0] r_timer;
    t_flags                 r_flags;
    logic [COUNT_WIDTH-1:0] timer_inc;
    logic [COUNT_WIDTH-1:0] n_timer;
    t_flags                 n_flags;
    logic                   is_long;

    // clears first, then the classification of this tick
    always_comb begin
        timer_inc = (r_timer == CNT_MAX) ? r_timer : r_timer + 1'b1;
        is_long   = CMP_W'(timer_inc) >= CMP_W'(i_long_ticks);
        n_flags   = r_flags;
        if (i_ctl.clr.was_pressed)  n_flags.was_pressed  = 1'b0;
        if (i_ctl.clr.was_released) n_flags.was_released = 1'b0;
        if (i_ctl.clr.was_short)    n_flags.was_short    = 1'b0;
        if (i_ctl.clr.was_long)     n_flags.was_long     = 1'b0;
        n_timer = '0;
        if (i_level) begin
            n_timer             = timer_inc;
            n_flags.was_pressed = 1'b1;
            if (is_long) begin
                n_flags.pressed_short = 1'b0;
                n_flags.pressed_long  = 1'b1;
                n_flags.was_long      = 1'b1;
            end else begin
                n_flags.pressed_short = 1'b1;
                n_flags.pressed_long  = 1'b0;
            end
        end else if (r_prev) begin
            // falling edge of the filtered level
            if (!is_long) n_flags.was_short = 1'b1;
            n_flags.was_released  = 1'b1;
            n_flags.pressed_short = 1'b0;
            n_flags.pressed_long  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= 1'b0;
            r_timer <= '0;
            r_flags <= '0;
        end else if (i_ctl.step) begin
            r_prev  <= i_level;
            r_timer <= n_timer;
            r_flags <= n_flags;
        end else if (i_ctl.load_prev) begin
            r_prev  <= i_ctl.prev_val;
        end
    end

    assign o_flags_next = n_flags;

endmodule

/* sv/button_debounce_long_press.sv */
// button_debounce_long_press: debounced button with short / long press flags
// a result is registered and valid in the cycle after its tick transfer
// one tick per cycle while each result is taken; the next tick is taken while the result is being taken
// state update is one pass through the filter compare and the press timer compare
// reset (synchronous, active low): released, counters and flags zero, registers 1000 / 20 / 0
module button_debounce_long_press (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    bdlp_in_if.sink                          i_in,
    bdlp_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [bdlp_pkg::REG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bdlp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bdlp_pkg::*;

    logic [CFG_DATA_W-1:0] r_long_ticks;
    logic [CFG_DATA_W-1:0] r_filter_ticks;
    logic                  r_out_valid;
    t_result               r_res;
    logic                  in_xfer;
    logic                  level_next;
    t_flags                flags_next;
    t_press_ctl            press_ctl;

    // input transfer whenever the result register is free or being emptied
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_xfer    = i_in.valid && i_in.ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ticks   <= LONG_PRESS_RST;
            r_filter_ticks <= FILTER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LONG_PRESS_TICKS: r_long_ticks   <= i_cfg_data;
                REG_FILTER_TICKS:     r_filter_ticks <= i_cfg_data;
                // initial level goes straight into the press tracker
                REG_INIT_PREV_LEVEL:  ;
                default: ;
            endcase
        end
    end

    // control to the press tracker
    always_comb begin
        press_ctl.step             = in_xfer;
        press_ctl.clr.was_pressed  = i_in.clear_was_pressed;
        press_ctl.clr.was_released = i_in.clear_was_released;
        press_ctl.clr.was_short    = i_in.clear_was_short;
        press_ctl.clr.was_long     = i_in.clear_was_long;
        press_ctl.load_prev        = i_cfg_we && (i_cfg_idx == REG_INIT_PREV_LEVEL);
        press_ctl.prev_val         = i_cfg_data[0];
    end

    bdlp_filter u_filter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (in_xfer),
        .i_raw          (i_in.raw_pressed),
        .i_filter_ticks (r_filter_ticks),
        .o_level_next   (level_next)
    );

    bdlp_press u_press (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (press_ctl),
        .i_level      (level_next),
        .i_long_ticks (r_long_ticks),
        .o_flags_next (flags_next)
    );

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_res.pressed <= level_next;
            r_res.flags   <= flags_next;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.pressed           = r_res.pressed;
    assign o_out.was_pressed       = r_res.flags.was_pressed;
    assign o_out.was_released      = r_res.flags.was_released;
    assign o_out.pressed_short     = r_res.flags.pressed_short;
    assign o_out.was_pressed_short = r_res.flags.was_short;
    assign o_out.pressed_long      = r_res.flags.pressed_long;
    assign o_out.was_pressed_long  = r_res.flags.was_long;

    // a tick transfer always leaves a result waiting
    a_xfer_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_out_valid)
        else $error("tick transfer without a result");

    // short and long are exclusive
    a_short_long_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_res.flags.pressed_short && r_res.flags.pressed_long))
        else $error("press reported short and long at once");

    // a pressed result always carries the sticky pressed flag
    a_pressed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.pressed) |-> r_res.flags.was_pressed)
        else $error("pressed without was_pressed");

    // a pressed result always carries a short or long classification
    a_class_needs_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.pressed) |->
            (r_res.flags.pressed_short || r_res.flags.pressed_long))
        else $error("pressed result without a classification");

endmodule

/* tb/bdlp_press_checker.sv */
// bdlp_press_checker: watches the tick and result channels of the button debounce block
// keeps its own copy of filter, press timer and flags; depends on bdlp_pkg, bdlp_in_if, bdlp_out_if
`timescale 1ns / 100ps
module bdlp_press_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    bdlp_in_if                               i_tick,
    bdlp_out_if                              i_res,
    input  logic                             i_cfg_we,
    input  logic [bdlp_pkg::REG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bdlp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                               o_pending,
    output int                               o_fail_count
);

    // register copies
    logic [bdlp_pkg::CFG_DATA_W-1:0]  long_thr;
    logic [bdlp_pkg::CFG_DATA_W-1:0]  filt_thr;

    // button state copies
    logic                             level;
    logic                             prev_level;
    logic [bdlp_pkg::COUNT_WIDTH-1:0] filt_cnt;
    logic [bdlp_pkg::COUNT_WIDTH-1:0] hold_timer;
    bdlp_pkg::t_flags                 flags;

    bdlp_pkg::t_result                status_due[$];
    int                               fail_total = 0;

    // one tick: clears, glitch filter, press timer, classification
    function automatic bdlp_pkg::t_result tick_status(input logic raw,
                                                      input bdlp_pkg::t_clears clr);
        bdlp_pkg::t_result res;
        logic              is_long;
        if (clr.was_pressed)  flags.was_pressed  = 1'b0;
        if (clr.was_released) flags.was_released = 1'b0;
        if (clr.was_short)    flags.was_short    = 1'b0;
        if (clr.was_long)     flags.was_long     = 1'b0;

        if (raw == level) begin
            filt_cnt = '0;
        end else begin
            if (filt_cnt != bdlp_pkg::CNT_MAX) filt_cnt = filt_cnt + 1'b1;
            if (filt_cnt >= filt_thr) begin
                level    = raw;
                filt_cnt = '0;
            end
        end

        if (hold_timer != bdlp_pkg::CNT_MAX) hold_timer = hold_timer + 1'b1;
        is_long = (hold_timer >= long_thr);

        if (level) begin
            flags.was_pressed   = 1'b1;
            flags.pressed_short = !is_long;
            flags.pressed_long  = is_long;
            if (is_long) flags.was_long = 1'b1;
        end else begin
            // falling edge of the filtered level
            if (prev_level) begin
                if (!is_long) flags.was_short = 1'b1;
                flags.was_released  = 1'b1;
                flags.pressed_short = 1'b0;
                flags.pressed_long  = 1'b0;
            end
            hold_timer = '0;
        end
        prev_level  = level;
        res.pressed = level;
        res.flags   = flags;
        return res;
    endfunction

    // result fields in port order, pressed in the top bit
    function automatic logic [6:0] status_bits(input bdlp_pkg::t_result r);
        return {r.pressed, r.flags.was_pressed, r.flags.was_released, r.flags.pressed_short,
                r.flags.was_short, r.flags.pressed_long, r.flags.was_long};
    endfunction

    function automatic string field_label(input int k);
        case (k)
            6: return "pressed";
            5: return "was_pressed";
            4: return "was_released";
            3: return "pressed_short";
            2: return "was_pressed_short";
            1: return "pressed_long";
            default: return "was_pressed_long";
        endcase
    endfunction

    task automatic note_failure(input string msg);
        fail_total++;
        if (fail_total <= 10) $display("%t %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin : watch
        bdlp_pkg::t_result want;
        bdlp_pkg::t_result got;
        logic [6:0]        want_bits;
        logic [6:0]        got_bits;
        if (!i_rst_n) begin
            long_thr   = bdlp_pkg::LONG_PRESS_RST;
            filt_thr   = bdlp_pkg::FILTER_RST;
            level      = 1'b0;
            prev_level = 1'b0;
            filt_cnt   = '0;
            hold_timer = '0;
            flags      = '0;
            status_due.delete();
        end else begin
            // register writes, unknown indexes fall through
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bdlp_pkg::REG_LONG_PRESS_TICKS: long_thr = i_cfg_data;
                    bdlp_pkg::REG_FILTER_TICKS:     filt_thr = i_cfg_data;
                    bdlp_pkg::REG_INIT_PREV_LEVEL:  prev_level = i_cfg_data[0];
                    default: ;
                endcase
            end

            // result transfer against the oldest expectation
            if (i_res.valid && i_res.ready) begin
                got.pressed             = i_res.pressed;
                got.flags.was_pressed   = i_res.was_pressed;
                got.flags.was_released  = i_res.was_released;
                got.flags.pressed_short = i_res.pressed_short;
                got.flags.was_short     = i_res.was_pressed_short;
                got.flags.pressed_long  = i_res.pressed_long;
                got.flags.was_long      = i_res.was_pressed_long;
                if (status_due.size() == 0) begin
                    note_failure("result transfer with nothing outstanding");
                end else begin
                    want      = status_due.pop_front();
                    want_bits = status_bits(want);
                    got_bits  = status_bits(got);
                    for (int k = 6; k >= 0; k--) begin
                        if (want_bits[k] !== got_bits[k])
                            note_failure($sformatf("mismatch %s: expected %b got %b",
                                                   field_label(k), want_bits[k], got_bits[k]));
                    end
                end
            end

            // tick transfer
            if (i_tick.valid && i_tick.ready)
                status_due.push_back(tick_status(i_tick.raw_pressed,
                                                 {i_tick.clear_was_pressed,
                                                  i_tick.clear_was_released,
                                                  i_tick.clear_was_short,
                                                  i_tick.clear_was_long}));
        end
        o_pending    <= status_due.size();
        o_fail_count <= fail_total;
    end

endmodule

/* tb/tb_button_debounce_long_press.sv */
// tb_button_debounce_long_press: stimulus and verdict for the button debounce block
// drives ticks, registers and result back-pressure; bdlp_press_checker does the checking
`timescale 1ns / 100ps
module tb_button_debounce_long_press;
    import bdlp_pkg::*;

    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam t_clears CLR_NONE    = '0;
    localparam t_clears CLR_ALL     = '1;
    localparam int      HOLD_CYCLES = 150;

    typedef enum logic {RX_FREE, RX_HOLD} t_rx_mode;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [REG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    pending;
    int                    fail_count;

    int                    tx_idle_pct;
    int                    rx_stall_pct;
    t_rx_mode              rx_mode;
    int                    cur_long;
    int                    cur_filt;

    bdlp_in_if  tick_ch ();
    bdlp_out_if res_ch ();

    button_debounce_long_press dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (tick_ch),
        .o_out      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    bdlp_press_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_tick       (tick_ch),
        .i_res        (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    // result side: random stalls, or one long hold-off at the start of a pressure phase
    initial begin : receiver
        int hold_left;
        hold_left    = HOLD_CYCLES;
        res_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rx_mode != RX_HOLD) hold_left = HOLD_CYCLES;
            if (rx_mode == RX_HOLD && hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                res_ch.ready <= ($urandom_range(99) < rx_stall_pct) ? 1'b0 : 1'b1;
            end
        end
    end

    // register write, enable raised and then lowered again so the enable never toggles twice in one step
    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
        if (idx == REG_LONG_PRESS_TICKS) cur_long = int'(data);
        if (idx == REG_FILTER_TICKS)     cur_filt = int'(data);
    endtask

    // one tick transfer, with random idle cycles first
    task automatic send_tick(input logic raw, input t_clears clr);
        while ($urandom_range(99) < tx_idle_pct) begin
            tick_ch.valid       <= 1'b0;
            tick_ch.raw_pressed <= 1'($urandom_range(1));
            @(posedge clk);
        end
        tick_ch.valid              <= 1'b1;
        tick_ch.raw_pressed        <= raw;
        tick_ch.clear_was_pressed  <= clr.was_pressed;
        tick_ch.clear_was_released <= clr.was_released;
        tick_ch.clear_was_short    <= clr.was_short;
        tick_ch.clear_was_long     <= clr.was_long;
        @(posedge clk);
        while (!tick_ch.ready) @(posedge clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_drained();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic t_clears random_clears();
        t_clears c;
        c.was_pressed  = ($urandom_range(7) == 0);
        c.was_released = ($urandom_range(7) == 0);
        c.was_short    = ($urandom_range(7) == 0);
        c.was_long     = ($urandom_range(7) == 0);
        return c;
    endfunction

    // alternating presses and releases around the thresholds, with bounces and glitches
    task automatic run_presses(input int n_items);
        int   sent;
        int   run_len;
        logic lvl;
        sent = 0;
        lvl  = 1'($urandom_range(1));
        while (sent < n_items) begin
            if ($urandom_range(4) == 0)
                run_len = $urandom_range(1, cur_filt + 1);
            else if (lvl)
                run_len = $urandom_range(cur_filt + 1, cur_filt + cur_long + 4);
            else
                run_len = $urandom_range(cur_filt + 1, 2 * cur_filt + 4);
            for (int k = 0; k < run_len && sent < n_items; k++) begin
                send_tick(lvl ^ ($urandom_range(15) == 0), random_clears());
                sent++;
            end
            lvl = !lvl;
        end
    endtask

    task automatic random_phase(input int tx_pct, input int rx_pct, input int long_v,
                                input int filt_v, input logic init_v, input int n_items);
        wait_drained();
        cfg_write(REG_LONG_PRESS_TICKS, CFG_DATA_W'(long_v));
        cfg_write(REG_FILTER_TICKS, CFG_DATA_W'(filt_v));
        cfg_write(REG_INIT_PREV_LEVEL, {15'd0, init_v});
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        run_presses(n_items);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
    endtask

    initial begin
        rst_n                      = 1'b0;
        cfg_we                     = 1'b0;
        cfg_idx                    = '0;
        cfg_data                   = '0;
        tick_ch.valid              = 1'b0;
        tick_ch.raw_pressed        = 1'b0;
        tick_ch.clear_was_pressed  = 1'b0;
        tick_ch.clear_was_released = 1'b0;
        tick_ch.clear_was_short    = 1'b0;
        tick_ch.clear_was_long     = 1'b0;
        tx_idle_pct                = 0;
        rx_stall_pct               = 0;
        rx_mode                    = RX_FREE;
        cur_long                   = int'(LONG_PRESS_RST);
        cur_filt                   = int'(FILTER_RST);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: press flips after twenty ticks, short release
        repeat (21) send_tick(1'b1, CLR_NONE);
        repeat (21) send_tick(1'b0, CLR_NONE);

        // unknown index ignored, initial level loaded with masked data
        wait_drained();
        cfg_write(REG_UNUSED, 16'hFFFF);
        cfg_write(REG_LONG_PRESS_TICKS, 16'd5);
        cfg_write(REG_FILTER_TICKS, 16'd2);
        cfg_write(REG_INIT_PREV_LEVEL, 16'hFFFF);
        send_tick(1'b0, CLR_NONE);              // falling edge from the initial level
        send_tick(1'b0, CLR_ALL);
        send_tick(1'b1, CLR_NONE);              // bounce shorter than the filter
        send_tick(1'b0, CLR_NONE);
        repeat (5) send_tick(1'b1, CLR_NONE);
        send_tick(1'b1, CLR_ALL);               // set wins over clear in the same tick
        repeat (3) send_tick(1'b0, CLR_NONE);   // release after a long press
        repeat (2) send_tick(1'b1, CLR_ALL);
        repeat (3) send_tick(1'b0, CLR_NONE);   // release of a short press

        // zero filter and zero long time
        wait_drained();
        cfg_write(REG_FILTER_TICKS, 16'd0);
        cfg_write(REG_LONG_PRESS_TICKS, 16'd0);
        send_tick(1'b1, CLR_NONE);
        send_tick(1'b0, CLR_NONE);
        send_tick(1'b1, CLR_ALL);
        send_tick(1'b0, CLR_ALL);
        wait_drained();
        cfg_write(REG_INIT_PREV_LEVEL, 16'h8001);
        send_tick(1'b0, CLR_ALL);
        wait_drained();
        cfg_write(REG_INIT_PREV_LEVEL, 16'h0002);
        send_tick(1'b0, CLR_ALL);

        // random presses under each idling pattern
        random_phase(0, 0, $urandom_range(1, 12), $urandom_range(0, 4), 1'b0, 80);
        random_phase(69, 0, $urandom_range(1, 12), $urandom_range(1, 4), 1'b1, 80);
        random_phase(0, 69, 0, 0, 1'b0, 80);
        random_phase(17, 17, $urandom_range(1, 20), $urandom_range(0, 6),
                     1'($urandom_range(1)), 80);

        // pressure: results held off while ticks keep being offered
        wait_drained();
        rx_mode = RX_HOLD;
        random_phase(0, 0, 4, 1, 1'b0, 80);
        wait_drained();
        rx_mode = RX_FREE;

        random_phase(17, 17, $urandom_range(0, 10), $urandom_range(0, 3), 1'b1, 60);

        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
